// ===== hw/rtl/temperature_to_led_pulse_codes_core_macros.svh =====
// Assertion macros shared by the temperature to LED pulse-code core.
// Used by the queue and the serializer; expects aclk and aresetn in scope.
`ifndef TEMPERATURE_TO_LED_PULSE_CODES_CORE_MACROS_SVH
`define TEMPERATURE_TO_LED_PULSE_CODES_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define TLPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TLPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/tlpc_pkg.sv =====
// Types and constants of the temperature to LED pulse-code core.
// No dependencies.
package tlpc_pkg;

    localparam int TEMP_W   = 8;
    localparam int WIDTH_W  = 16;
    localparam int REPEAT_W = 6;
    localparam int CFG_ADDR_W = 8;
    localparam int BITS_PER_COLOUR = 24;
    localparam int BITCNT_W = 5;

    localparam logic [REPEAT_W-1:0] RESET_SLOTS = 6'd50;
    localparam logic [REPEAT_W-1:0] DATA_REPEAT = 6'd1;

    localparam logic [WIDTH_W-1:0] ONE_WIDTH_RST  = 16'd60;
    localparam logic [WIDTH_W-1:0] ZERO_WIDTH_RST = 16'd30;

    localparam logic [CFG_ADDR_W-1:0] REG_ONE_WIDTH  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_WIDTH = 8'd1;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } colour_t;

endpackage

// ===== hw/rtl/tlpc_front.sv =====
// Front end: takes temperature transactions, picks the band and builds the colour.
// Depends on tlpc_pkg; feeds tlpc_queue.
module tlpc_front
    import tlpc_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TEMP_W-1:0] s_temperature,
    input  logic              q_full,
    output logic              q_push,
    output colour_t           q_colour
);

    typedef enum logic [2:0] {
        BAND_COLD = 3'b001,
        BAND_MID  = 3'b010,
        BAND_HOT  = 3'b100
    } band_t;

    band_t      band;
    logic [7:0] d_mid;
    logic [7:0] d_hot;
    logic [7:0] t10;
    logic [7:0] mid10;
    logic [7:0] hot10;
    logic [7:0] hot5;

    always_comb begin
        if (s_temperature <= 8'd25) begin
            band = BAND_COLD;
        end else if (s_temperature <= 8'd50) begin
            band = BAND_MID;
        end else begin
            band = BAND_HOT;
        end
    end

    assign d_mid = s_temperature - 8'd25;
    assign d_hot = s_temperature - 8'd50;
    assign t10   = 8'(s_temperature * 8'd10);
    assign mid10 = 8'(d_mid * 8'd10);
    assign hot10 = 8'(d_hot * 8'd10);
    assign hot5  = 8'(d_hot * 8'd5);

    always_comb begin
        q_colour = '0;
        case (band)
            BAND_COLD: begin
                q_colour.blue  = 8'd255 - t10;
                q_colour.green = t10;
            end
            BAND_MID: begin
                q_colour.green = 8'd255 - mid10;
                q_colour.red   = mid10;
            end
            BAND_HOT: begin
                q_colour.red  = 8'd255 - hot10;
                q_colour.blue = hot5;
            end
            default: begin
                q_colour = '0;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ===== hw/rtl/tlpc_queue.sv =====
// Short colour queue between the front end and the serializer.
// Depends on tlpc_pkg and the assertion macro header.
`include "temperature_to_led_pulse_codes_core_macros.svh"

module tlpc_queue
    import tlpc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  colour_t push_colour,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output colour_t pop_colour
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    colour_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign pop_colour = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_colour;
        end
    end

    `TLPC_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `TLPC_ASSERT(a_no_pop_empty, (pop && !not_empty) |=> (count_reg == $past(count_reg) + CNT_W'($past(do_push))), "pop on empty queue changed count")
    `TLPC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !not_empty, "queue not empty after reset")

endmodule

// ===== hw/rtl/tlpc_serializer.sv =====
// Back end: shifts each colour out MSB first as pulse-width transactions,
// then one reset-run transaction. Depends on tlpc_pkg and the macro header.
`include "temperature_to_led_pulse_codes_core_macros.svh"

module tlpc_serializer
    import tlpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  colour_t            q_colour,
    output logic               q_pop,
    input  logic [WIDTH_W-1:0] one_width,
    input  logic [WIDTH_W-1:0] zero_width,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [WIDTH_W-1:0] m_pulse_width,
    output logic [REPEAT_W-1:0] m_repeat_count,
    output logic               m_last_slot
);

    logic [BITS_PER_COLOUR-1:0] shift_reg;
    logic [BITS_PER_COLOUR-1:0] shift_next;
    logic [BITCNT_W-1:0]        bit_cnt_reg;
    logic [BITCNT_W-1:0]        bit_cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [WIDTH_W-1:0]         width_reg;
    logic [WIDTH_W-1:0]         width_next;
    logic [REPEAT_W-1:0]        repeat_reg;
    logic [REPEAT_W-1:0]        repeat_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       load;

    assign load = !valid_reg || m_tready;

    always_comb begin
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        valid_next   = valid_reg && !m_tready;
        width_next   = width_reg;
        repeat_next  = repeat_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        if (load) begin
            if (busy_reg) begin
                valid_next = 1'b1;
                if (bit_cnt_reg == BITCNT_W'(BITS_PER_COLOUR)) begin
                    width_next   = '0;
                    repeat_next  = RESET_SLOTS;
                    last_next    = 1'b1;
                    busy_next    = 1'b0;
                    bit_cnt_next = '0;
                end else begin
                    width_next   = shift_reg[BITS_PER_COLOUR-1] ? one_width : zero_width;
                    repeat_next  = DATA_REPEAT;
                    last_next    = 1'b0;
                    shift_next   = {shift_reg[BITS_PER_COLOUR-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end else if (q_not_empty) begin
                q_pop        = 1'b1;
                valid_next   = 1'b1;
                width_next   = q_colour[BITS_PER_COLOUR-1] ? one_width : zero_width;
                repeat_next  = DATA_REPEAT;
                last_next    = 1'b0;
                shift_next   = {q_colour[BITS_PER_COLOUR-2:0], 1'b0};
                bit_cnt_next = BITCNT_W'(1);
                busy_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            bit_cnt_reg <= bit_cnt_next;
            busy_reg    <= busy_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        width_reg  <= width_next;
        repeat_reg <= repeat_next;
        last_reg   <= last_next;
    end

    assign m_tvalid       = valid_reg;
    assign m_pulse_width  = width_reg;
    assign m_repeat_count = repeat_reg;
    assign m_last_slot    = last_reg;

    `TLPC_ASSERT(a_cnt_range, bit_cnt_reg <= BITCNT_W'(BITS_PER_COLOUR), "bit counter out of range")
    `TLPC_ASSERT(a_frame_continues, (valid_reg && m_tready && !last_reg) |=> valid_reg, "gap inside a frame")
    `TLPC_ASSERT(a_last_is_reset_run, (valid_reg && last_reg) |-> (width_reg == '0 && repeat_reg == RESET_SLOTS && !busy_reg), "bad reset-run transaction")
    `TLPC_ASSERT(a_pop_idle_only, q_pop |-> (!busy_reg && load), "queue popped mid frame")

endmodule

// ===== hw/rtl/temperature_to_led_pulse_codes_core.sv =====
// The first pulse transaction of a temperature is registered in the queue, then in the
// serializer's output register. Each temperature gives 25 output transactions (24 bits plus
// reset run), one per cycle while m_tready is high, from the serializer's single output slot.
// The front end keeps accepting while the queue of QUEUE_DEPTH colours has room.
// Reset (aresetn low, synchronous): queue and serializer empty, one_width = 60,
// zero_width = 30.
module temperature_to_led_pulse_codes_core
    import tlpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WIDTH_W-1:0]    cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] temperature
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [15:0] pulse_width, [21:16] repeat_count, zero fill
    output logic                  m_tlast    // last_slot
);

    logic [WIDTH_W-1:0]  one_width_reg;
    logic [WIDTH_W-1:0]  zero_width_reg;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_not_empty;
    colour_t             push_colour;
    colour_t             pop_colour;
    logic [WIDTH_W-1:0]  pulse_width;
    logic [REPEAT_W-1:0] repeat_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_width_reg  <= ONE_WIDTH_RST;
            zero_width_reg <= ZERO_WIDTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ONE_WIDTH:  one_width_reg  <= cfg_wdata;
                REG_ZERO_WIDTH: zero_width_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tlpc_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_temperature (s_tdata[TEMP_W-1:0]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_colour      (push_colour)
    );

    tlpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_colour (push_colour),
        .full        (q_full),
        .pop         (q_pop),
        .not_empty   (q_not_empty),
        .pop_colour  (pop_colour)
    );

    tlpc_serializer u_serializer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_colour       (pop_colour),
        .q_pop          (q_pop),
        .one_width      (one_width_reg),
        .zero_width     (zero_width_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_pulse_width  (pulse_width),
        .m_repeat_count (repeat_count),
        .m_last_slot    (m_tlast)
    );

    assign m_tdata = {2'b00, repeat_count, pulse_width};

endmodule
